// File: hdl/ptuv_pkg.sv
`timescale 1ns / 1ps

package ptuv_pkg;

  // Output format and pipeline geometry.
  localparam int OutFracBits  = 30;
  localparam int CordicStages = 32;
  localparam int RedSteps     = 15;
  localparam int ScLatency    = 1 + RedSteps + 3 + CordicStages + 1;
  localparam int TotalLatency = 3 + ScLatency + 3;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgCenterTwice = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRadPerPixel = 1'b1;

  localparam logic [15:0] CenterTwiceReset = 16'd1023;
  localparam logic [39:0] RadPerPixelReset = 40'd16930000;

  typedef logic signed [63:0] atan_tab_t [CordicStages];

  // Sine and cosine of one angle, both Q.60.
  typedef struct packed {
    logic signed [63:0] sin_v;
    logic signed [63:0] cos_v;
  } sincos_t;

  // Unsigned restoring division, used only to build constants at elaboration.
  function automatic logic [63:0] udiv64_f(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] part;
    q    = '0;
    part = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, den}) begin
        part = part - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1) in Q.62 by Machin's formula, elaborated once.
  function automatic logic [63:0] quarter_pi_q62_f();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] a5;
    logic [63:0] a239;
    logic        neg;
    a5   = '0;
    a239 = '0;
    for (int j = 0; j < 2; j++) begin
      m   = (j == 0) ? 64'd5 : 64'd239;
      p   = udiv64_f(64'd1 << 62, m);
      sum = '0;
      k   = 64'd1;
      neg = 1'b0;
      for (int n = 0; n < 64; n++) begin
        if (p != 0) begin
          t   = udiv64_f(p, k);
          sum = neg ? sum - t : sum + t;
          neg = !neg;
          p   = udiv64_f(p, m * m);
          k   = k + 64'd2;
        end
      end
      if (j == 0) begin
        a5 = sum;
      end else begin
        a239 = sum;
      end
    end
    return 64'd4 * a5 - a239;
  endfunction

  // Arctangent table for the rotation stages, Q.60.
  function automatic atan_tab_t atan_table_f();
    atan_tab_t   tab;
    logic [63:0] sum;
    logic [63:0] t;
    logic        neg;
    int          k;
    int          e;
    tab[0] = $signed((quarter_pi_q62_f() + 64'd2) >> 2);
    for (int i = 1; i < CordicStages; i++) begin
      sum = '0;
      k   = 1;
      neg = 1'b0;
      e   = 62 - i;
      for (int n = 0; n < 64; n++) begin
        if (e >= 0) begin
          t   = udiv64_f(64'd1 << e, 64'(k));
          sum = neg ? sum - t : sum + t;
          neg = !neg;
          k   = k + 2;
          e   = 62 - i * k;
        end
      end
      tab[i] = $signed((sum + 64'd2) >> 2);
    end
    return tab;
  endfunction

  // Rotation gain, Q.60: square root of the product of 1/(1 + 4^-i).
  function automatic logic [63:0] gain_q60_f();
    logic [63:0] k2;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] rem;
    logic [63:0] k62;
    k2 = 64'd1 << 62;
    for (int i = 0; i < CordicStages; i++) begin
      if (i < 32) begin
        k2 = k2 - udiv64_f(k2, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    n    = k2;
    r    = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > n) begin
        bitv = bitv >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (n >= r + bitv) begin
          n = n - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    rem = k2 - r * r;
    k62 = (r << 31) + ((r != 0) ? udiv64_f(rem << 30, r) : 64'd0);
    return (k62 + 64'd2) >> 2;
  endfunction

  localparam logic [46:0] TwoPiQ44 =
      47'((64'd4 * quarter_pi_q62_f() + (64'd1 << 16)) >> 17);
  localparam logic signed [63:0] TwoPiQ60  = $signed({1'b0, TwoPiQ44, 16'b0});
  localparam logic signed [63:0] PiQ60     = $signed({2'b0, TwoPiQ44, 15'b0});
  localparam logic signed [63:0] HalfPiQ60 = $signed({3'b0, TwoPiQ44, 14'b0});
  localparam logic signed [63:0] GainQ60   = $signed(gain_q60_f());
  localparam atan_tab_t          AtanQ60   = atan_table_f();

endpackage

// File: hdl/pixel_to_unit_vector.sv
`timescale 1ns / 1ps

// valid_o marks each result; data pass offset, scale, angle, sine/cosine, round, product, output.
// Throughput: one transaction per cycle; busy is never raised, since the receiver cannot stall.
// Depth is set mostly by the 15 modulo steps and 32 rotation stages of each sine/cosine unit.
// Reset: asynchronous, active low; clears the valid pipeline and loads register defaults.
module pixel_to_unit_vector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [15:0]                      pix_x_i,
  input  logic [15:0]                      pix_y_i,
  input  logic                             cfg_we_i,
  input  logic [ptuv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [39:0]                      cfg_wdata_i,
  output logic                             valid_o,
  output logic signed [31:0]               vec_x_o,
  output logic signed [31:0]               vec_y_o,
  output logic signed [31:0]               vec_z_o
);

  localparam int Lat      = ptuv_pkg::TotalLatency;
  localparam int RndShift = 29;
  localparam int YShift   = 60 - ptuv_pkg::OutFracBits;
  localparam int FinShift = 62 - ptuv_pkg::OutFracBits;
  localparam logic signed [33:0] OutLim = 34'sd1 <<< ptuv_pkg::OutFracBits;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  logic [15:0] ct_q;
  logic [39:0] rpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q  <= ptuv_pkg::CenterTwiceReset;
      rpp_q <= ptuv_pkg::RadPerPixelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptuv_pkg::CfgCenterTwice: ct_q  <= cfg_wdata_i[15:0];
        ptuv_pkg::CfgRadPerPixel: rpp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data stages.
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  assign valid_o = vld_q[Lat-1];

  // Stage 1: pixel offsets from the center, Q.4.
  logic signed [20:0] dx_q;
  logic signed [20:0] dy_q;
  logic signed [20:0] c8;

  assign c8 = $signed({2'b0, ct_q, 3'b0});

  always_ff @(posedge clk_i) begin
    dx_q <= $signed({5'b0, pix_x_i}) - c8;
    dy_q <= c8 - $signed({5'b0, pix_y_i});
  end

  // Stage 2: partial products with the two halves of the pixel scale.
  logic signed [41:0] pxl_q, pxh_q, pyl_q, pyh_q;
  logic signed [20:0] rlo;
  logic signed [20:0] rhi;

  assign rlo = $signed({1'b0, rpp_q[19:0]});
  assign rhi = $signed({1'b0, rpp_q[39:20]});

  always_ff @(posedge clk_i) begin
    pxl_q <= dx_q * rlo;
    pxh_q <= dx_q * rhi;
    pyl_q <= dy_q * rlo;
    pyh_q <= dy_q * rhi;
  end

  // Stage 3: angles in Q.44.
  logic signed [63:0] ra_q;
  logic signed [63:0] de_q;

  always_ff @(posedge clk_i) begin
    ra_q <= 64'(pxl_q) + (64'(pxh_q) <<< 20);
    de_q <= 64'(pyl_q) + (64'(pyh_q) <<< 20);
  end

  // Sine and cosine units.
  ptuv_pkg::sincos_t sc_ra;
  ptuv_pkg::sincos_t sc_de;

  ptuv_sincos u_sc_ra (
    .clk_i   (clk_i),
    .angle_i (ra_q),
    .sc_o    (sc_ra)
  );

  ptuv_sincos u_sc_de (
    .clk_i   (clk_i),
    .angle_i (de_q),
    .sc_o    (sc_de)
  );

  // Round the factors to Q.31 and vec_y to the output scale.
  logic signed [33:0] cde_q, sra_q, ncra_q, yv_q;
  logic signed [33:0] cra_r;

  assign cra_r = 34'((sc_ra.cos_v + (64'sd1 <<< (RndShift - 1))) >>> RndShift);

  always_ff @(posedge clk_i) begin
    cde_q  <= 34'((sc_de.cos_v + (64'sd1 <<< (RndShift - 1))) >>> RndShift);
    sra_q  <= 34'((sc_ra.sin_v + (64'sd1 <<< (RndShift - 1))) >>> RndShift);
    ncra_q <= -cra_r;
    yv_q   <= 34'((sc_de.sin_v + (64'sd1 <<< (YShift - 1))) >>> YShift);
  end

  // Products in Q.62.
  logic signed [63:0] prx_q;
  logic signed [63:0] prz_q;
  logic signed [33:0] yv2_q;

  always_ff @(posedge clk_i) begin
    prx_q <= cde_q * sra_q;
    prz_q <= cde_q * ncra_q;
    yv2_q <= yv_q;
  end

  // Final rounding and saturation to plus or minus one.
  logic signed [33:0] rx, rz;
  logic signed [33:0] sx, sy, sz;

  assign rx = 34'((prx_q + (64'sd1 <<< (FinShift - 1))) >>> FinShift);
  assign rz = 34'((prz_q + (64'sd1 <<< (FinShift - 1))) >>> FinShift);

  always_comb begin
    sx = (rx > OutLim) ? OutLim : ((rx < -OutLim) ? -OutLim : rx);
    sy = (yv2_q > OutLim) ? OutLim : ((yv2_q < -OutLim) ? -OutLim : yv2_q);
    sz = (rz > OutLim) ? OutLim : ((rz < -OutLim) ? -OutLim : rz);
  end

  always_ff @(posedge clk_i) begin
    vec_x_o <= sx[31:0];
    vec_y_o <= sy[31:0];
    vec_z_o <= sz[31:0];
  end

`ifndef NO_ASSERTIONS
  localparam logic signed [31:0] Lim32 = 32'sd1 <<< ptuv_pkg::OutFracBits;

  a_valid_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, Lat))
    else $error("result strobe without a matching start");

  a_vec_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (vec_x_o <= Lim32) && (vec_x_o >= -Lim32))
    else $error("vec_x outside unit range");

  a_vec_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (vec_y_o <= Lim32) && (vec_y_o >= -Lim32))
    else $error("vec_y outside unit range");

  a_vec_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (vec_z_o <= Lim32) && (vec_z_o >= -Lim32))
    else $error("vec_z outside unit range");
`endif

endmodule

// File: hdl/ptuv_sincos.sv
`timescale 1ns / 1ps

module ptuv_sincos (
  input  logic                     clk_i,
  input  logic signed [63:0]       angle_i,
  output ptuv_pkg::sincos_t        sc_o
);

  localparam int Rs = ptuv_pkg::RedSteps;
  localparam int Cs = ptuv_pkg::CordicStages;

  // Magnitude and sign of the Q.44 angle.
  logic [60:0] mag_q [Rs+1];
  logic        neg_q [Rs+1];

  always_ff @(posedge clk_i) begin
    neg_q[0] <= angle_i[63];
    mag_q[0] <= angle_i[63] ? 61'(-angle_i) : 61'(angle_i);
  end

  // Modulo 2*pi, one restoring subtract of a shifted 2*pi per stage.
  for (genvar k = 0; k < Rs; k++) begin : g_red
    localparam logic [60:0] Sub = 61'(ptuv_pkg::TwoPiQ44) << (Rs - 1 - k);
    always_ff @(posedge clk_i) begin
      neg_q[k+1] <= neg_q[k];
      mag_q[k+1] <= (mag_q[k] >= Sub) ? mag_q[k] - Sub : mag_q[k];
    end
  end

  // Negative angles land on 2*pi minus the remainder.
  logic [46:0] rem_q;

  always_ff @(posedge clk_i) begin
    if (neg_q[Rs] && (mag_q[Rs] != '0)) begin
      rem_q <= ptuv_pkg::TwoPiQ44 - mag_q[Rs][46:0];
    end else begin
      rem_q <= mag_q[Rs][46:0];
    end
  end

  // Move to Q.60 and wrap into [-pi, pi).
  logic signed [63:0] wrap_d;
  logic signed [63:0] wrap_q;

  always_comb begin
    wrap_d = $signed({1'b0, rem_q, 16'b0});
    if (wrap_d >= ptuv_pkg::PiQ60) begin
      wrap_d = wrap_d - ptuv_pkg::TwoPiQ60;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
  end

  // Mirror angles beyond a quarter turn; the cosine flips sign.
  logic signed [63:0] x_q [Cs+1];
  logic signed [63:0] y_q [Cs+1];
  logic signed [63:0] z_q [Cs+1];
  logic               flip_q [Cs+1];

  always_ff @(posedge clk_i) begin
    x_q[0] <= ptuv_pkg::GainQ60;
    y_q[0] <= '0;
    if (wrap_q > ptuv_pkg::HalfPiQ60) begin
      z_q[0]    <= ptuv_pkg::PiQ60 - wrap_q;
      flip_q[0] <= 1'b1;
    end else if (wrap_q < -ptuv_pkg::HalfPiQ60) begin
      z_q[0]    <= -ptuv_pkg::PiQ60 - wrap_q;
      flip_q[0] <= 1'b1;
    end else begin
      z_q[0]    <= wrap_q;
      flip_q[0] <= 1'b0;
    end
  end

  // Rotation stages, one micro-rotation each.
  for (genvar i = 0; i < Cs; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][63]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ptuv_pkg::AtanQ60[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ptuv_pkg::AtanQ60[i];
      end
    end
  end

  // Result register with the quadrant sign applied to the cosine.
  always_ff @(posedge clk_i) begin
    sc_o.sin_v <= y_q[Cs];
    sc_o.cos_v <= flip_q[Cs] ? -x_q[Cs] : x_q[Cs];
  end

endmodule

// File: bench/tb_pixel_to_unit_vector.sv
`timescale 1ns / 1ps

module tb_pixel_to_unit_vector;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] pix_x_i;
  logic [15:0] pix_y_i;
  logic        cfg_we_i;
  logic [ptuv_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [39:0] cfg_wdata_i;
  logic        valid_o;
  logic signed [31:0] vec_x_o;
  logic signed [31:0] vec_y_o;
  logic signed [31:0] vec_z_o;

  // Pixels waiting to be sent and unit vectors waiting to come back.
  logic [31:0] pixel_queue[$];
  vec_t        vector_queue[$];

  // Local copy of the block's registers and constant tables.
  logic [15:0] center_twice_q;
  logic [39:0] rad_per_pixel_q;
  longint      atan_tab[32];
  longint      gain_c;
  longint      two_pi_c;
  longint      pi_c;
  longint      half_pi_c;

  int          send_idle_pct;
  int          n_driven;
  int          n_taken;
  bit          failed;

  pixel_to_unit_vector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_x_i     (pix_x_i),
    .pix_y_i     (pix_y_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .vec_x_o     (vec_x_o),
    .vec_y_o     (vec_y_o),
    .vec_z_o     (vec_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Arctangent of 1/m in Q.62 by its alternating series.
  function automatic longint unsigned atan_recip(longint unsigned m);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned k;
    bit              neg;
    p   = (64'd1 << 62) / m;
    sum = 0;
    k   = 1;
    neg = 1'b0;
    while (p != 0) begin
      sum = neg ? sum - p / k : sum + p / k;
      neg = !neg;
      p   = p / (m * m);
      k   = k + 2;
    end
    return sum;
  endfunction

  // Build the rotation angles, gain and pi constants once.
  function automatic void build_constants();
    longint unsigned a0;
    longint unsigned sum;
    longint unsigned k2;
    longint unsigned n;
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned k62;
    longint          k;
    longint          e;
    bit              neg;
    a0 = 4 * atan_recip(5) - atan_recip(239);
    atan_tab[0] = longint'((a0 + 2) >> 2);
    for (int i = 1; i < 32; i++) begin
      sum = 0;
      k   = 1;
      neg = 1'b0;
      e   = 62 - i;
      while (e >= 0) begin
        sum = neg ? sum - (64'd1 << e) / k : sum + (64'd1 << e) / k;
        neg = !neg;
        k   = k + 2;
        e   = 62 - i * k;
      end
      atan_tab[i] = longint'((sum + 2) >> 2);
    end
    two_pi_c  = longint'((4 * a0 + (64'd1 << 16)) >> 17);
    pi_c      = two_pi_c * 32768;
    half_pi_c = two_pi_c * 16384;
    k2 = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
    end
    n    = k2;
    r    = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    k62    = (r << 31) + ((r != 0) ? ((k2 - r * r) << 30) / r : 0);
    gain_c = longint'((k62 + 2) >> 2);
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Sine and cosine in Q.60 of an angle in Q.44, by range reduction and CORDIC.
  function automatic void angle_sincos(longint ang, output longint s, output longint c);
    longint r;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    r = ang % two_pi_c;
    if (r < 0) r = r + two_pi_c;
    z    = r * 65536;
    flip = 1'b0;
    if (z >= pi_c) z = z - 2 * pi_c;
    if (z > half_pi_c) begin
      z    = pi_c - z;
      flip = 1'b1;
    end else if (z < -half_pi_c) begin
      z    = -pi_c - z;
      flip = 1'b1;
    end
    x = gain_c;
    y = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Round Q.62 to Q1.30 and clamp to plus or minus one.
  function automatic logic [31:0] to_q30(longint v);
    longint w;
    w = rnd_shift(v, 32);
    if (w > (longint'(1) << 30)) w = longint'(1) << 30;
    if (w < -(longint'(1) << 30)) w = -(longint'(1) << 30);
    return w[31:0];
  endfunction

  function automatic vec_t pixel_vector(logic [15:0] px, logic [15:0] py);
    vec_t   v;
    longint c8;
    longint rpp;
    longint sra;
    longint cra;
    longint sde;
    longint cde;
    longint c31;
    c8  = 8 * longint'({48'b0, center_twice_q});
    rpp = longint'({24'b0, rad_per_pixel_q});
    angle_sincos((longint'({48'b0, px}) - c8) * rpp, sra, cra);
    angle_sincos((c8 - longint'({48'b0, py})) * rpp, sde, cde);
    c31  = rnd_shift(cde, 29);
    v.vx = to_q30(c31 * rnd_shift(sra, 29));
    v.vy = to_q30(sde * 4);
    v.vz = to_q30(-(c31 * rnd_shift(cra, 29)));
    return v;
  endfunction

  // Sender: a new pixel only once the previous transaction was taken.
  always @(negedge clk_i) begin
    if (rst_ni && start && n_taken != n_driven) begin
      start <= 1'b1;
    end else if (rst_ni && pixel_queue.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      start   <= 1'b1;
      pix_x_i <= pixel_queue[0][31:16];
      pix_y_i <= pixel_queue[0][15:0];
      void'(pixel_queue.pop_front());
      n_driven <= n_driven + 1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: track register writes, predict on acceptance, check results.
  always @(posedge clk_i) begin
    vec_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ptuv_pkg::CfgCenterTwice) center_twice_q = cfg_wdata_i[15:0];
        else if (cfg_idx_i == ptuv_pkg::CfgRadPerPixel) rad_per_pixel_q = cfg_wdata_i;
      end
      if (start && !busy) begin
        vector_queue.push_back(pixel_vector(pix_x_i, pix_y_i));
        n_taken <= n_taken + 1;
      end
      if (valid_o) begin
        if (vector_queue.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h", $time, vec_x_o, vec_y_o,
                   vec_z_o);
          failed = 1'b1;
        end else begin
          e = vector_queue.pop_front();
          if (vec_x_o !== e.vx) begin
            $display("%0t: vec_x expected %h actual %h", $time, e.vx, vec_x_o);
            failed = 1'b1;
          end
          if (vec_y_o !== e.vy) begin
            $display("%0t: vec_y expected %h actual %h", $time, e.vy, vec_y_o);
            failed = 1'b1;
          end
          if (vec_z_o !== e.vz) begin
            $display("%0t: vec_z expected %h actual %h", $time, e.vz, vec_z_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_queue.size() > 0 || n_taken != n_driven || vector_queue.size() > 0);
  endtask

  task automatic write_reg(logic [ptuv_pkg::CfgIdxW-1:0] idx, logic [39:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Coordinates mostly inside the image, some anywhere in the field.
  function automatic logic [15:0] rand_coord();
    int c;
    if ($urandom_range(3) == 0) return 16'($urandom);
    c = 8 * int'(center_twice_q) + $urandom_range(512) - 256;
    if ($urandom_range(1) == 0) c = $urandom_range(16 * int'(center_twice_q) + 16);
    return 16'(c);
  endfunction

  // Stimulus: settings per phase, directed corners first, then random pixels.
  initial begin
    logic [15:0] cen_set[6];
    logic [39:0] rad_set[6];
    int          mid;
    build_constants();
    center_twice_q  = ptuv_pkg::CenterTwiceReset;
    rad_per_pixel_q = ptuv_pkg::RadPerPixelReset;
    failed        = 1'b0;
    n_driven      = 0;
    n_taken       = 0;
    send_idle_pct = 10;
    rst_ni      = 1'b0;
    start       = 1'b0;
    pix_x_i     = '0;
    pix_y_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = ptuv_pkg::CfgCenterTwice;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cen_set = '{16'd1023, 16'd0, 16'hFFFF, 16'd2047, 16'($urandom), 16'd511};
    rad_set = '{40'd16930000, 40'd0, 40'hFF_FFFF_FFFF, 40'd400000000,
                40'($urandom) | (40'($urandom_range(255)) << 32), 40'd1 << 30};

    // Directed corners under reset settings.
    mid = 8 * 1023;
    pixel_queue.push_back({16'd0, 16'd0});
    pixel_queue.push_back({16'hFFFF, 16'hFFFF});
    pixel_queue.push_back({16'd0, 16'hFFFF});
    pixel_queue.push_back({16'hFFFF, 16'd0});
    pixel_queue.push_back({16'(mid), 16'(mid)});
    pixel_queue.push_back({16'(mid + 1), 16'(mid - 1)});
    pixel_queue.push_back({16'h5555, 16'hAAAA});
    pixel_queue.push_back({16'hAAAA, 16'h5555});
    pixel_queue.push_back({16'(2 * mid), 16'd0});
    pixel_queue.push_back({16'd0, 16'(2 * mid)});
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 50 : 0;
      write_reg(ptuv_pkg::CfgCenterTwice, {24'b0, cen_set[ph]});
      write_reg(ptuv_pkg::CfgRadPerPixel, rad_set[ph]);
      // Extremes under every setting, including huge angles and saturation.
      pixel_queue.push_back({16'hFFFF, 16'd0});
      pixel_queue.push_back({16'd0, 16'hFFFF});
      pixel_queue.push_back({16'(8 * int'(cen_set[ph])), 16'(8 * int'(cen_set[ph]))});
      for (int i = 0; i < 255; i++) begin
        pixel_queue.push_back({rand_coord(), rand_coord()});
      end
      wait_drained();
    end

    repeat (70) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
